FILE: hw/rtl/rct_pkg.sv
// Shared types, character codes and helpers for the command tokenizer.
// No dependencies; imported by rct_parser and resp_command_tokenizer_unit.
`timescale 1ns / 1ps

package rct_pkg;

    localparam int NUMBER_BITS_DEF = 31;
    localparam int MAX_RESULTS     = 3;

    // parse phases
    typedef enum logic [3:0] {
        PH_START  = 4'd0,
        PH_INLINE = 4'd1,
        PH_CNT0   = 4'd2,
        PH_CNT    = 4'd3,
        PH_CNTCR  = 4'd4,
        PH_MARK   = 4'd5,
        PH_LEN0   = 4'd6,
        PH_LEN    = 4'd7,
        PH_LENCR  = 4'd8,
        PH_PAY    = 4'd9,
        PH_SKIP   = 4'd10,
        PH_DONE   = 4'd11,
        PH_STOP   = 4'd12
    } rct_phase_t;

    // result kinds
    localparam logic [1:0] KIND_BYTE    = 2'd0;
    localparam logic [1:0] KIND_DONE    = 2'd1;
    localparam logic [1:0] KIND_DISCARD = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    // character codes
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef struct packed {
        logic       stop;
        logic [7:0] data;
        logic [1:0] kind;
    } rct_result_t;

    // results caused by one input word, slot 0 first
    typedef struct packed {
        logic [1:0]                    count;
        rct_result_t [MAX_RESULTS-1:0] res;
    } rct_bundle_t;

    function automatic rct_bundle_t rct_push(rct_bundle_t bnd, logic [1:0] kind,
                                             logic [7:0] data, logic stop);
        rct_bundle_t r;
        r = bnd;
        r.res[bnd.count].kind = kind;
        r.res[bnd.count].data = data;
        r.res[bnd.count].stop = stop;
        r.count = bnd.count + 2'd1;
        return r;
    endfunction

endpackage

FILE: hw/rtl/rct_parser.sv
// Parse state registers and the per-byte step logic of the tokenizer.
// Depends on rct_pkg.
`timescale 1ns / 1ps

module rct_parser
    import rct_pkg::*;
#(
    parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [7:0]  in_byte,
    input  logic        msg_last,
    output rct_bundle_t bundle
);

    localparam int NB = NUMBER_BITS;
    localparam int WB = NUMBER_BITS + 4;

    rct_phase_t      phase_reg, phase_next;
    logic [NB-1:0]   elem_reg, elem_next;
    logic [NB-1:0]   acc_reg, acc_next;
    logic [NB-1:0]   pay_reg, pay_next;
    logic [1:0]      skip_reg, skip_next;
    logic            in_tok_reg, in_tok_next;

    logic            is_digit;
    logic            is_space;
    logic [WB-1:0]   acc_x10;
    logic            ovf;

    assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    assign is_space = (in_byte == CH_SPACE) || ((in_byte >= CH_TAB) && (in_byte <= CH_CR));
    // acc * 10 + digit as two shifts and two adds
    assign acc_x10  = ({4'd0, acc_reg} << 3) + ({4'd0, acc_reg} << 1)
                    + WB'(in_byte[3:0]);
    assign ovf      = |acc_x10[WB-1:NB];

    always_comb begin
        rct_bundle_t bnd;
        logic        consumed;
        logic        stop;
        bnd         = '0;
        consumed    = 1'b0;
        stop        = 1'b0;
        phase_next  = phase_reg;
        elem_next   = elem_reg;
        acc_next    = acc_reg;
        pay_next    = pay_reg;
        skip_next   = skip_reg;
        in_tok_next = in_tok_reg;

        if (phase_reg == PH_START) begin
            if (in_byte == CH_STAR) begin
                acc_next   = '0;
                phase_next = PH_CNT0;
                consumed   = 1'b1;
            end else begin
                in_tok_next = 1'b0;
                phase_next  = PH_INLINE;
            end
        end

        if (!consumed) begin
            unique case (phase_next)
                PH_INLINE: begin
                    if (is_space) begin
                        if (in_tok_next) begin
                            bnd         = rct_push(bnd, KIND_DONE, 8'd0, 1'b0);
                            in_tok_next = 1'b0;
                        end
                    end else begin
                        bnd         = rct_push(bnd, KIND_BYTE, in_byte, 1'b0);
                        in_tok_next = 1'b1;
                    end
                end
                PH_CNT0, PH_CNT, PH_LEN0, PH_LEN: begin
                    if (is_digit) begin
                        if (ovf) begin
                            phase_next = PH_STOP;
                        end else begin
                            acc_next   = acc_x10[NB-1:0];
                            phase_next = (phase_reg == PH_CNT0 || phase_reg == PH_CNT) ?
                                         PH_CNT : PH_LEN;
                        end
                    end else if (in_byte == CH_CR && phase_reg == PH_CNT) begin
                        phase_next = PH_CNTCR;
                    end else if (in_byte == CH_CR && phase_reg == PH_LEN) begin
                        phase_next = PH_LENCR;
                    end else begin
                        phase_next = PH_STOP;
                    end
                end
                PH_CNTCR: begin
                    if (in_byte == CH_LF) begin
                        elem_next  = acc_reg;
                        phase_next = (acc_reg != '0) ? PH_MARK : PH_DONE;
                    end else begin
                        phase_next = PH_STOP;
                    end
                end
                PH_MARK: begin
                    if (in_byte == CH_DOLLAR) begin
                        acc_next   = '0;
                        phase_next = PH_LEN0;
                    end else begin
                        phase_next = PH_STOP;
                    end
                end
                PH_LENCR: begin
                    if (in_byte == CH_LF) begin
                        pay_next = acc_reg;
                        if (acc_reg == '0) begin
                            // empty token closes on the LF
                            bnd        = rct_push(bnd, KIND_DONE, 8'd0, 1'b0);
                            elem_next  = (elem_reg != '0) ? elem_reg - NB'(1) : elem_reg;
                            skip_next  = 2'd2;
                            phase_next = PH_SKIP;
                        end else begin
                            phase_next = PH_PAY;
                        end
                    end else begin
                        phase_next = PH_STOP;
                    end
                end
                PH_PAY: begin
                    bnd      = rct_push(bnd, KIND_BYTE, in_byte, 1'b0);
                    pay_next = pay_reg - NB'(1);
                    if (pay_reg == NB'(1)) begin
                        bnd        = rct_push(bnd, KIND_DONE, 8'd0, 1'b0);
                        elem_next  = (elem_reg != '0) ? elem_reg - NB'(1) : elem_reg;
                        skip_next  = 2'd2;
                        phase_next = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    if (skip_reg != 2'd0) begin
                        skip_next = skip_reg - 2'd1;
                    end
                    if (skip_next == 2'd0) begin
                        phase_next = (elem_reg != '0) ? PH_MARK : PH_DONE;
                    end
                end
                default: begin
                    // done, stopped and unused codes ignore the byte
                end
            endcase
        end

        if (msg_last) begin
            unique case (phase_next)
                PH_INLINE: begin
                    if (in_tok_next) begin
                        bnd = rct_push(bnd, KIND_DONE, 8'd0, 1'b0);
                    end
                    stop = 1'b0;
                end
                PH_DONE:   stop = 1'b0;
                PH_SKIP:   stop = (elem_next != '0);
                PH_PAY: begin
                    bnd  = rct_push(bnd, KIND_DISCARD, 8'd0, 1'b0);
                    stop = 1'b1;
                end
                default:   stop = 1'b1;
            endcase
            bnd         = rct_push(bnd, KIND_END, 8'd0, stop);
            phase_next  = PH_START;
            elem_next   = '0;
            acc_next    = '0;
            pay_next    = '0;
            skip_next   = 2'd0;
            in_tok_next = 1'b0;
        end

        bundle = bnd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_START;
            elem_reg   <= '0;
            acc_reg    <= '0;
            pay_reg    <= '0;
            skip_reg   <= 2'd0;
            in_tok_reg <= 1'b0;
        end else if (step) begin
            phase_reg  <= phase_next;
            elem_reg   <= elem_next;
            acc_reg    <= acc_next;
            pay_reg    <= pay_next;
            skip_reg   <= skip_next;
            in_tok_reg <= in_tok_next;
        end
    end

endmodule

FILE: hw/rtl/resp_command_tokenizer_unit.sv
// Top level of the command tokenizer: stream ports, result buffer and drain.
// Depends on rct_pkg and rct_parser.
`timescale 1ns / 1ps

// Command tokenizer. Takes a command message one byte per input word
// (s_tlast on its final byte) and streams out its tokens. A message whose
// first byte is '*' is parsed as an array of length-prefixed strings
// ("*<count>CRLF" then per element "$<len>CRLF", payload, two skipped bytes);
// any other message is split on whitespace. Each result word carries a kind
// (token byte, token complete, discard partial token, message end), the byte
// and, on message end, a flag set when the parse stopped on malformed or
// truncated data; m_tlast marks the final result of one input byte.
// Timing: a byte is parsed in the cycle it is accepted and its results (zero
// to three) land in a result register, which drains one word per cycle while
// m_tready is high. The input is ready while that register is empty or
// delivering its last word, so with m_tready high a byte giving at most one
// result is taken every cycle and a byte giving more holds the input while
// its earlier results drain. Results appear in the cycle after acceptance.

module resp_command_tokenizer_unit
    import rct_pkg::*;
#(
    parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // message_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [1:0] result_kind, [9:2] token_byte,
                                   // [10] stopped_early, [15:11] zero
    output logic        m_tlast    // last_of_run
);

    rct_bundle_t                   bundle;
    rct_result_t [MAX_RESULTS-1:0] res_reg, res_next;
    logic [1:0]                    rem_reg, rem_next;   // words left to deliver
    logic                          s_fire, m_fire;

    assign m_tvalid = (rem_reg != 2'd0);
    assign m_tlast  = (rem_reg == 2'd1);
    assign m_tdata  = {5'd0, res_reg[0].stop, res_reg[0].data, res_reg[0].kind};
    assign m_fire   = m_tvalid && m_tready;
    // take a byte when the buffer is empty or its last word leaves now
    assign s_tready = (rem_reg == 2'd0) || ((rem_reg == 2'd1) && m_tready);
    assign s_fire   = s_tvalid && s_tready;

    rct_parser #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (s_fire),
        .in_byte  (s_tdata),
        .msg_last (s_tlast),
        .bundle   (bundle)
    );

    always_comb begin
        res_next = res_reg;
        rem_next = rem_reg;
        if (s_fire) begin
            res_next = bundle.res;
            rem_next = bundle.count;
        end else if (m_fire) begin
            // shift the queue down one slot
            res_next[0] = res_reg[1];
            res_next[1] = res_reg[2];
            rem_next    = rem_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= 2'd0;
        end else begin
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

endmodule

FILE: hw/rtl/rct_checker.sv
// Port-level checks on the tokenizer's result stream, bound to the top level.
// Depends on rct_pkg and resp_command_tokenizer_unit's ports.
`timescale 1ns / 1ps

module rct_checker
    import rct_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    // stalled word stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word withdrawn while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result word changed while stalled");

    // message end is always the final word of its run
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == KIND_END |-> m_tlast)
        else $error("message end not last of run");

    // stop flag only on message end
    a_stop_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[10] |-> m_tdata[1:0] == KIND_END)
        else $error("stop flag on a non-end word");

    // byte field is zero unless a token byte
    a_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != KIND_BYTE |-> m_tdata[9:2] == 8'd0)
        else $error("byte field set on a non-byte word");

endmodule

bind resp_command_tokenizer_unit rct_checker u_rct_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

FILE: verif/tb_resp_command_tokenizer_unit.sv
// Self-checking testbench for resp_command_tokenizer_unit: directed and random
// command messages, with a tokenizer model predicting every result word.
// Depends on rct_pkg and the tokenizer RTL.
`timescale 1ns / 1ps

module tb_resp_command_tokenizer_unit;
    import rct_pkg::*;

    localparam logic [7:0]  CH_VT   = 8'h0B;
    localparam logic [7:0]  CH_FF   = 8'h0C;
    localparam logic [63:0] NUM_MAX = (64'd1 << NUMBER_BITS_DEF) - 64'd1;

    typedef logic [7:0] msg_t[$];

    typedef struct {
        logic [1:0] kind;
        logic [7:0] data;
        logic       stop;
        logic       last;
    } tok_word_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;

    resp_command_tokenizer_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // tokenizer model state
    rct_phase_t                 phase;
    logic [NUMBER_BITS_DEF-1:0] elems_left;
    logic [NUMBER_BITS_DEF-1:0] num_acc;
    logic [NUMBER_BITS_DEF-1:0] pay_left;
    logic [1:0]                 skip_left;
    logic                       in_token;

    tok_word_t   due_words[$];   // predicted result words, oldest first
    int unsigned faults     = 0;
    int unsigned burst_left = 0;
    bit          tx_gaps    = 1'b0;
    bit          rx_stalls  = 1'b0;
    int unsigned rx_hold    = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(2_000_000);
        $display("Verification failed");
        $finish;
    end

    // ---------------------------------------------------------------- model

    function automatic void clear_parse();
        phase      = PH_START;
        elems_left = '0;
        num_acc    = '0;
        pay_left   = '0;
        skip_left  = 2'd0;
        in_token   = 1'b0;
    endfunction

    function automatic bit is_blank(input logic [7:0] b);
        return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

    // false on overflow, accumulator untouched then
    function automatic bit take_digit(input logic [7:0] b);
        logic [63:0] v;
        v = 64'(num_acc) * 64'd10 + 64'(b) - 64'(CH_ZERO);
        if (v > NUM_MAX)
            return 1'b0;
        num_acc = v[NUMBER_BITS_DEF-1:0];
        return 1'b1;
    endfunction

    function automatic void add_word(ref tok_word_t q[$], input logic [1:0] kind,
                                     input logic [7:0] data, input logic stop);
        tok_word_t w;
        w.kind = kind;
        w.data = data;
        w.stop = stop;
        w.last = 1'b0;
        q.insert(q.size(), w);
    endfunction

    function automatic void close_element(ref tok_word_t q[$]);
        add_word(q, KIND_DONE, 8'd0, 1'b0);
        if (elems_left != 0)
            elems_left--;
        skip_left = 2'd2;
        phase     = PH_SKIP;
    endfunction

    // predicts the result words of one accepted input byte
    function automatic void tokenize_byte(input logic [7:0] b, input logic last);
        tok_word_t fresh[$];
        bit        used;
        bit        dig;
        logic      stop;
        used = 1'b0;
        dig  = b >= CH_ZERO && b <= CH_NINE;
        if (phase == PH_START) begin
            if (b == CH_STAR) begin
                num_acc = '0;
                phase   = PH_CNT0;
                used    = 1'b1;
            end else begin
                in_token = 1'b0;
                phase    = PH_INLINE;
            end
        end
        if (!used) begin
            case (phase)
                PH_INLINE: begin
                    if (is_blank(b)) begin
                        if (in_token) begin
                            add_word(fresh, KIND_DONE, 8'd0, 1'b0);
                            in_token = 1'b0;
                        end
                    end else begin
                        add_word(fresh, KIND_BYTE, b, 1'b0);
                        in_token = 1'b1;
                    end
                end
                PH_CNT0, PH_CNT: begin
                    if (dig)
                        phase = take_digit(b) ? PH_CNT : PH_STOP;
                    else if (b == CH_CR && phase == PH_CNT)
                        phase = PH_CNTCR;
                    else
                        phase = PH_STOP;
                end
                PH_CNTCR: begin
                    if (b == CH_LF) begin
                        elems_left = num_acc;
                        phase      = (elems_left != 0) ? PH_MARK : PH_DONE;
                    end else begin
                        phase = PH_STOP;
                    end
                end
                PH_MARK: begin
                    if (b == CH_DOLLAR) begin
                        num_acc = '0;
                        phase   = PH_LEN0;
                    end else begin
                        phase = PH_STOP;
                    end
                end
                PH_LEN0, PH_LEN: begin
                    if (dig)
                        phase = take_digit(b) ? PH_LEN : PH_STOP;
                    else if (b == CH_CR && phase == PH_LEN)
                        phase = PH_LENCR;
                    else
                        phase = PH_STOP;
                end
                PH_LENCR: begin
                    if (b == CH_LF) begin
                        pay_left = num_acc;
                        if (pay_left == 0)
                            close_element(fresh);
                        else
                            phase = PH_PAY;
                    end else begin
                        phase = PH_STOP;
                    end
                end
                PH_PAY: begin
                    add_word(fresh, KIND_BYTE, b, 1'b0);
                    pay_left--;
                    if (pay_left == 0)
                        close_element(fresh);
                end
                PH_SKIP: begin
                    if (skip_left != 0)
                        skip_left--;
                    if (skip_left == 0)
                        phase = (elems_left != 0) ? PH_MARK : PH_DONE;
                end
                default: ;  // done or stopped: byte ignored
            endcase
        end
        if (last) begin
            if (phase == PH_INLINE) begin
                if (in_token)
                    add_word(fresh, KIND_DONE, 8'd0, 1'b0);
                stop = 1'b0;
            end else if (phase == PH_DONE) begin
                stop = 1'b0;
            end else if (phase == PH_SKIP) begin
                stop = elems_left != 0;
            end else begin
                if (phase == PH_PAY)
                    add_word(fresh, KIND_DISCARD, 8'd0, 1'b0);
                stop = 1'b1;
            end
            add_word(fresh, KIND_END, 8'd0, stop);
            clear_parse();
        end
        foreach (fresh[i]) begin
            fresh[i].last = (i == fresh.size() - 1);
            due_words.insert(due_words.size(), fresh[i]);
        end
    endfunction

    // -------------------------------------------------------- result side

    // receiver stall pattern: ready and stalled stretches of random length
    always @(negedge aclk) begin
        if (!rx_stalls) begin
            m_tready = 1'b1;
        end else if (rx_hold != 0) begin
            rx_hold--;
        end else begin
            m_tready = !m_tready;
            if (m_tready)
                rx_hold = $urandom_range(0, ($urandom_range(0, 3) == 0) ? 20 : 3);
            else
                rx_hold = $urandom_range(0, 4);
        end
    end

    // every accepted result word against the oldest prediction
    always @(posedge aclk) begin
        tok_word_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (due_words.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("%0t: unexpected word kind %0d data %02h stop %0b last %0b",
                             $realtime, m_tdata[1:0], m_tdata[9:2], m_tdata[10], m_tlast);
            end else begin
                want = due_words.pop_front();
                if (m_tdata[1:0] !== want.kind || m_tdata[9:2] !== want.data ||
                    m_tdata[10] !== want.stop || m_tdata[15:11] !== 5'd0 ||
                    m_tlast !== want.last) begin
                    faults++;
                    if (faults <= 10)
                        $display({"%0t: mismatch exp kind %0d data %02h stop %0b last %0b",
                                  " / got kind %0d data %02h stop %0b last %0b pad %02h"},
                                 $realtime, want.kind, want.data, want.stop, want.last,
                                 m_tdata[1:0], m_tdata[9:2], m_tdata[10], m_tlast,
                                 m_tdata[15:11]);
                end
            end
        end
    end

    // --------------------------------------------------------- input side

    // one byte; with tx_gaps set the sender works in bursts with idle gaps between them
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (tx_gaps && burst_left == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = last;
        do @(posedge aclk); while (!s_tready);
        tokenize_byte(b, last);
        if (burst_left != 0)
            burst_left--;
        @(negedge aclk);
    endtask

    task automatic send_msg(ref msg_t m);
        foreach (m[i])
            send_byte(m[i], i == m.size() - 1);
    endtask

    task automatic wait_all_delivered();
        s_tvalid = 1'b0;
        while (due_words.size() != 0)
            @(negedge aclk);
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 5))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            3:       return CH_VT;
            4:       return CH_FF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic void append_byte(ref msg_t m, input logic [7:0] b);
        m.insert(m.size(), b);
    endfunction

    function automatic void put_decimal(ref msg_t m, input logic [63:0] v);
        msg_t digits;
        do begin
            digits.push_front(CH_ZERO + 8'(v % 10));
            v = v / 10;
        end while (v != 0);
        foreach (digits[i])
            append_byte(m, digits[i]);
    endfunction

    function automatic logic [63:0] overflow_value();
        if ($urandom_range(0, 3) == 0)
            return 64'd99999999999;
        return NUM_MAX + 64'd1 + 64'($urandom_range(0, 1 << 20));
    endfunction

    // an array message; five in twelve are clean, the rest carry one flaw
    function automatic void build_array(ref msg_t m);
        int unsigned flaw;
        int unsigned count;
        int unsigned len;
        int unsigned cut;
        m    = {};
        flaw = $urandom_range(0, 11);
        count = $urandom_range(1, 3);
        append_byte(m, CH_STAR);
        if (flaw == 7)
            put_decimal(m, overflow_value());
        else if (flaw == 9)
            put_decimal(m, NUM_MAX);      // most elements never arrive
        else
            put_decimal(m, 64'(count));
        append_byte(m, CH_CR);
        append_byte(m, CH_LF);
        if (flaw == 9)
            count = $urandom_range(1, 2);
        for (int e = 0; e < count; e++) begin
            append_byte(m, CH_DOLLAR);
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
            if (flaw == 8 && e == 0)
                put_decimal(m, overflow_value());
            else if (flaw == 10 && e == 0)
                put_decimal(m, NUM_MAX);  // message ends inside this payload
            else
                put_decimal(m, 64'(len));
            append_byte(m, CH_CR);
            append_byte(m, CH_LF);
            if ((flaw == 8 || flaw == 10) && e == 0) begin
                repeat ($urandom_range(1, 3))
                    append_byte(m, 8'($urandom_range(0, 255)));
                return;
            end
            repeat (len)
                append_byte(m, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1) == 0) begin
                append_byte(m, CH_CR);
                append_byte(m, CH_LF);
            end else begin
                append_byte(m, 8'($urandom_range(0, 255)));
                append_byte(m, 8'($urandom_range(0, 255)));
            end
        end
        case (flaw)
            5: begin
                cut = $urandom_range(1, m.size() - 1);
                while (m.size() > cut)
                    void'(m.pop_back());
            end
            6: m[$urandom_range(0, m.size() - 1)] = 8'($urandom_range(0, 255));
            11: begin
                if ($urandom_range(0, 1) == 0) begin
                    repeat ($urandom_range(1, 3))
                        append_byte(m, 8'($urandom_range(0, 255)));
                end else begin
                    repeat ($urandom_range(1, 2))
                        void'(m.pop_back());
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void build_inline(ref msg_t m);
        m = {};
        repeat ($urandom_range(1, 10)) begin
            if ($urandom_range(0, 9) < 4)
                append_byte(m, pick_blank());
            else
                append_byte(m, 8'($urandom_range(0, 255)));
        end
    endfunction

    // ---------------------------------------------------------------- tests

    // every whitespace code, the bytes either side of the blank range and
    // the extremes; the final token is still open at the message end
    task automatic test_inline_whitespace();
        msg_t m;
        m = '{8'h08, CH_SPACE, 8'h00, CH_TAB, 8'hFF, CH_LF, CH_VT, CH_FF, CH_CR, 8'h0E};
        send_msg(m);
        m = '{CH_SPACE};
        send_msg(m);
    endtask

    // lone marker, zero count, and a zero-length element ending the message
    task automatic test_array_edges();
        msg_t m;
        m = '{CH_STAR};
        send_msg(m);
        m = '{CH_STAR, CH_ZERO, CH_CR, CH_LF};
        send_msg(m);
        m = '{CH_STAR, CH_ZERO + 8'd1, CH_CR, CH_LF, CH_DOLLAR, CH_ZERO, CH_CR, CH_LF};
        send_msg(m);
    endtask

    task automatic test_random_arrays(input int unsigned n_bytes);
        msg_t        m;
        int unsigned sent;
        sent = 0;
        while (sent < n_bytes) begin
            build_array(m);
            send_msg(m);
            sent += m.size();
        end
    endtask

    task automatic test_random_inline(input int unsigned n_bytes);
        msg_t        m;
        int unsigned sent;
        sent = 0;
        while (sent < n_bytes) begin
            build_inline(m);
            send_msg(m);
            sent += m.size();
        end
    endtask

    // full-rate input and an always-ready receiver
    task automatic test_back_to_back();
        tx_gaps   = 1'b0;
        rx_stalls = 1'b0;
        test_random_arrays(5);
        test_random_inline(4);
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;
    endtask

    // sender holds off until every predicted word has gone out
    task automatic test_pause_until_drained();
        msg_t m;
        build_array(m);
        send_msg(m);
        wait_all_delivered();
        build_inline(m);
        send_msg(m);
    endtask

    initial begin
        clear_parse();
        repeat (6) @(negedge aclk);
        aresetn   = 1'b1;
        tx_gaps   = 1'b1;
        rx_stalls = 1'b1;

        test_inline_whitespace();
        test_array_edges();
        test_random_arrays(10);
        test_random_inline(6);
        test_back_to_back();
        test_pause_until_drained();

        wait_all_delivered();
        repeat (10) @(negedge aclk);
        if (faults == 0 && due_words.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
